/* sv/qlg_pkg.sv */
// ============================================================================
// qlg_pkg
// Shared types and constants of the Q-learning grid-world step engine.
// ============================================================================
package qlg_pkg;

    // Default values of the top-level parameters
    localparam int GRID_DIM_DEF    = 5;
    localparam int VALUE_WIDTH_DEF = 16;

    // Action set is fixed at four moves
    localparam int NUM_ACTIONS = 4;
    localparam int ACT_W       = 2;

    localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UP    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DOWN  = 2'd3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_REWARD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_REWARD     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EPISODE_LIMIT   = 3'd7;

    // Register reset values
    localparam logic [15:0]        LEARNING_RATE_RST   = 16'd19661;
    localparam logic [15:0]        DISCOUNT_FACTOR_RST = 16'd58982;
    localparam logic [15:0]        EPSILON_START_RST   = 16'd13107;
    localparam logic [15:0]        EPSILON_DECAY_RST   = 16'd65208;
    localparam logic [15:0]        EPSILON_FLOOR_RST   = 16'd655;
    localparam logic signed [15:0] GOAL_REWARD_RST     = 16'sd4096;
    localparam logic signed [15:0] MOVE_REWARD_RST     = -16'sd410;
    localparam logic [15:0]        EPISODE_LIMIT_RST   = 16'd500;

    // Rounding offset for Q0.16 products
    localparam int RND_HALF = 32768;

    typedef struct packed {
        logic [15:0]      explore_draw;
        logic [ACT_W-1:0] random_action;
    } t_step_in;

    typedef struct packed {
        logic [ACT_W-1:0]   action_taken;
        logic               explored;
        logic [2:0]         new_row;
        logic [2:0]         new_col;
        logic signed [15:0] updated_value;
        logic               episode_ended;
        logic [15:0]        episode_number;
        logic               training_done;
    } t_step_out;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // latch item, read current row
        logic report_done;  // training finished, report only
        logic choose;       // pick action and move, read next row
        logic take_max;     // register next-state maximum
        logic calc_td;      // register temporal difference
        logic commit;       // write back Q, update agent, emit result
    } t_qlg_cmd;

    // Datapath to controller
    typedef struct packed {
        logic limit_hit;
    } t_qlg_stat;

endpackage

/* sv/qlg_ram.sv */
// ============================================================================
// qlg_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module qlg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/qlg_ctrl.sv */
// ============================================================================
// qlg_ctrl
// Step sequencer: accept, choose, next-state max, TD, commit; report only at limit.
// ============================================================================
module qlg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  qlg_pkg::t_qlg_stat  i_stat,
    output qlg_pkg::t_qlg_cmd   o_cmd,
    output logic                busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR,
        S_NXT,
        S_TD,
        S_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.limit_hit) begin
                        o_cmd.report_done = 1'b1;
                    end else begin
                        n_state = S_CUR;
                    end
                end
            end
            S_CUR: begin
                o_cmd.choose = 1'b1;
                n_state      = S_NXT;
            end
            S_NXT: begin
                o_cmd.take_max = 1'b1;
                n_state        = S_TD;
            end
            S_TD: begin
                o_cmd.calc_td = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

    a_step_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && !o_cmd.report_done) |-> ##4 o_cmd.commit)
        else $error("accepted step did not reach commit");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.choose, o_cmd.take_max, o_cmd.calc_td, o_cmd.commit}))
        else $error("more than one step phase active");

    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with sequencer state");

endmodule

/* sv/qlg_dp.sv */
// ============================================================================
// qlg_dp
// Datapath: config registers, agent state, Q table with row valid bits,
// epsilon-greedy selection, fixed-point Q update and result register.
// ============================================================================
module qlg_dp #(
    parameter int GRID_DIM    = qlg_pkg::GRID_DIM_DEF,
    parameter int VALUE_WIDTH = qlg_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  qlg_pkg::t_qlg_cmd                 i_cmd,
    output qlg_pkg::t_qlg_stat                o_stat,
    input  qlg_pkg::t_step_in                 i_item,
    input  logic                              i_cfg_we,
    input  logic [qlg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [qlg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_strobe,
    output qlg_pkg::t_step_out                o_result
);

    localparam int VW     = VALUE_WIDTH;
    localparam int NA     = qlg_pkg::NUM_ACTIONS;
    localparam int AW     = qlg_pkg::ACT_W;
    localparam int CELLS  = GRID_DIM * GRID_DIM;
    localparam int CELL_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(GRID_DIM);
    localparam int ROW_W  = VW * NA;
    localparam int RW     = (VW > 16) ? VW : 16;
    localparam int TD_W   = RW + 3;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(GRID_DIM - 1);
    localparam logic [CELL_W-1:0] GRID_C = CELL_W'(GRID_DIM);

    localparam logic signed [VW+16:0]   HALF_G = (VW + 17)'(qlg_pkg::RND_HALF);
    localparam logic signed [TD_W+16:0] HALF_A = (TD_W + 17)'(qlg_pkg::RND_HALF);
    localparam logic signed [TD_W+1:0]  Q_HI   = {{(TD_W + 3 - VW){1'b0}}, {(VW - 1){1'b1}}};
    localparam logic signed [TD_W+1:0]  Q_LO   = {{(TD_W + 3 - VW){1'b1}}, {(VW - 1){1'b0}}};

    // Configuration registers
    logic [15:0]        r_alpha, r_gamma, r_decay, r_floor, r_limit;
    logic signed [15:0] r_goal_rew, r_move_rew;

    // Agent state
    logic [POS_W-1:0]   r_row, r_col;
    logic [15:0]        r_eps, r_episodes;
    logic [CELLS-1:0]   r_valid;

    // Step registers
    logic               r_expl;
    logic [AW-1:0]      r_ract, r_act;
    logic [POS_W-1:0]   r_nr, r_nc;
    logic               r_goal;
    logic [CELL_W-1:0]  r_cur_cell;
    logic [ROW_W-1:0]   r_row_cur;
    logic               r_rd_vld;
    logic signed [VW-1:0]   r_maxq;
    logic signed [TD_W-1:0] r_td;

    logic               r_strobe;
    qlg_pkg::t_step_out r_result;

    function automatic logic [AW-1:0] f_best(input logic [ROW_W-1:0] row);
        logic [AW-1:0]        b;
        logic signed [VW-1:0] bv;
        logic signed [VW-1:0] v;
        b  = '0;
        bv = row[0 +: VW];
        for (int a = 1; a < NA; a++) begin
            v = row[a*VW +: VW];
            if (v > bv) begin
                b  = AW'(a);
                bv = v;
            end
        end
        return b;
    endfunction

    function automatic logic signed [VW-1:0] f_entry(input logic [ROW_W-1:0] row,
                                                     input logic [AW-1:0]    idx);
        logic signed [VW-1:0] v;
        v = row[0 +: VW];
        for (int a = 1; a < NA; a++) begin
            if (idx == AW'(a)) begin
                v = row[a*VW +: VW];
            end
        end
        return v;
    endfunction

    // ---------------------------------------------------------------- table
    logic [ROW_W-1:0]  rd_data, row_rd, wr_data;
    logic [CELL_W-1:0] rd_addr, cur_cell, nxt_cell;
    logic              rd_en;

    qlg_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CELLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_cur_cell),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // A row never written reads as zero
    assign row_rd = r_rd_vld ? rd_data : '0;

    // ---------------------------------------------------------------- choose
    logic [AW-1:0]    act_c;
    logic [POS_W-1:0] nr_c, nc_c;

    assign cur_cell = CELL_W'(r_row) * GRID_C + CELL_W'(r_col);
    assign act_c    = r_expl ? r_ract : f_best(row_rd);

    always_comb begin
        nr_c = r_row;
        nc_c = r_col;
        case (act_c)
            qlg_pkg::ACT_LEFT:  if (r_col != '0)     nc_c = r_col - 1'b1;
            qlg_pkg::ACT_RIGHT: if (r_col != POS_MAX) nc_c = r_col + 1'b1;
            qlg_pkg::ACT_UP:    if (r_row != '0)     nr_c = r_row - 1'b1;
            qlg_pkg::ACT_DOWN:  if (r_row != POS_MAX) nr_c = r_row + 1'b1;
            default: ;
        endcase
    end

    assign nxt_cell = CELL_W'(nr_c) * GRID_C + CELL_W'(nc_c);
    assign rd_addr  = i_cmd.choose ? nxt_cell : cur_cell;
    assign rd_en    = i_cmd.accept | i_cmd.choose;

    // ---------------------------------------------------------------- TD
    logic signed [VW+16:0]  prod_g, sum_g;
    logic signed [VW:0]     fut;
    logic signed [VW-1:0]   q_sel;
    logic signed [TD_W-1:0] td_rew, td_fut, td_q, td_c;

    assign prod_g = $signed({1'b0, r_gamma}) * r_maxq;
    assign sum_g  = prod_g + HALF_G;
    assign fut    = sum_g[VW+16:16];
    assign q_sel  = f_entry(r_row_cur, r_act);
    assign td_rew = r_goal ? TD_W'(r_goal_rew) : TD_W'(r_move_rew);
    assign td_fut = TD_W'(fut);
    assign td_q   = TD_W'(q_sel);
    assign td_c   = td_rew + td_fut - td_q;

    // ---------------------------------------------------------------- update
    logic signed [TD_W+16:0] prod_a, sum_a;
    logic signed [TD_W:0]    step_a;
    logic signed [TD_W+1:0]  newq_w;
    logic signed [VW-1:0]    newq;
    logic [31:0]             eps_prod;
    logic [15:0]             eps_dec, eps_next;

    assign prod_a = $signed({1'b0, r_alpha}) * r_td;
    assign sum_a  = prod_a + HALF_A;
    assign step_a = sum_a[TD_W+16:16];
    assign newq_w = (TD_W + 2)'(q_sel) + (TD_W + 2)'(step_a);

    always_comb begin
        if (newq_w > Q_HI) begin
            newq = Q_HI[VW-1:0];
        end else if (newq_w < Q_LO) begin
            newq = Q_LO[VW-1:0];
        end else begin
            newq = newq_w[VW-1:0];
        end
    end

    always_comb begin
        wr_data = r_row_cur;
        for (int a = 0; a < NA; a++) begin
            if (r_act == AW'(a)) begin
                wr_data[a*VW +: VW] = newq;
            end
        end
    end

    assign eps_prod = 32'(r_eps) * 32'(r_decay);
    assign eps_dec  = eps_prod[31:16];
    assign eps_next = (eps_dec > r_floor) ? eps_dec : r_floor;

    assign o_stat.limit_hit = (r_episodes >= r_limit);

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= qlg_pkg::LEARNING_RATE_RST;
            r_gamma     <= qlg_pkg::DISCOUNT_FACTOR_RST;
            r_decay     <= qlg_pkg::EPSILON_DECAY_RST;
            r_floor     <= qlg_pkg::EPSILON_FLOOR_RST;
            r_goal_rew  <= qlg_pkg::GOAL_REWARD_RST;
            r_move_rew  <= qlg_pkg::MOVE_REWARD_RST;
            r_limit     <= qlg_pkg::EPISODE_LIMIT_RST;
            r_eps       <= qlg_pkg::EPSILON_START_RST;
            r_episodes  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_valid     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= i_cmd.report_done | i_cmd.commit;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    qlg_pkg::CFG_LEARNING_RATE:   r_alpha    <= i_cfg_data;
                    qlg_pkg::CFG_DISCOUNT_FACTOR: r_gamma    <= i_cfg_data;
                    qlg_pkg::CFG_EPSILON_START:   r_eps      <= i_cfg_data;
                    qlg_pkg::CFG_EPSILON_DECAY:   r_decay    <= i_cfg_data;
                    qlg_pkg::CFG_EPSILON_FLOOR:   r_floor    <= i_cfg_data;
                    qlg_pkg::CFG_GOAL_REWARD:     r_goal_rew <= $signed(i_cfg_data);
                    qlg_pkg::CFG_MOVE_REWARD:     r_move_rew <= $signed(i_cfg_data);
                    qlg_pkg::CFG_EPISODE_LIMIT:   r_limit    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_valid[r_cur_cell] <= 1'b1;
                if (r_goal) begin
                    // episode over: back to start, decay epsilon
                    r_row      <= '0;
                    r_col      <= '0;
                    r_eps      <= eps_next;
                    r_episodes <= r_episodes + 16'd1;
                end else begin
                    r_row <= r_nr;
                    r_col <= r_nc;
                end
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vld <= r_valid[rd_addr];
        end
        if (i_cmd.accept) begin
            r_expl     <= (i_item.explore_draw < r_eps);
            r_ract     <= i_item.random_action;
            r_cur_cell <= cur_cell;
        end
        if (i_cmd.choose) begin
            r_act     <= act_c;
            r_nr      <= nr_c;
            r_nc      <= nc_c;
            r_goal    <= (nr_c == POS_MAX) && (nc_c == POS_MAX);
            r_row_cur <= row_rd;
        end
        if (i_cmd.take_max) begin
            // goal row is never written, its max is zero
            r_maxq <= r_goal ? '0 : f_entry(row_rd, f_best(row_rd));
        end
        if (i_cmd.calc_td) begin
            r_td <= td_c;
        end
        if (i_cmd.report_done) begin
            r_result.action_taken   <= qlg_pkg::ACT_LEFT;
            r_result.explored       <= 1'b0;
            r_result.new_row        <= 3'(r_row);
            r_result.new_col        <= 3'(r_col);
            r_result.updated_value  <= '0;
            r_result.episode_ended  <= 1'b0;
            r_result.episode_number <= r_episodes;
            r_result.training_done  <= 1'b1;
        end else if (i_cmd.commit) begin
            r_result.action_taken   <= r_act;
            r_result.explored       <= r_expl;
            r_result.new_row        <= 3'(r_nr);
            r_result.new_col        <= 3'(r_nc);
            r_result.updated_value  <= 16'(newq);
            r_result.episode_ended  <= r_goal;
            r_result.episode_number <= r_goal ? r_episodes + 16'd1 : r_episodes;
            r_result.training_done  <= 1'b0;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_on_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= POS_MAX) && (r_col <= POS_MAX))
        else $error("agent left the grid");

    a_goal_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.episode_ended) |-> (r_row == '0 && r_col == '0))
        else $error("agent not returned to start after goal");

    a_eps_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.episode_ended) |-> (r_eps >= r_floor))
        else $error("epsilon decayed below floor");

endmodule

/* sv/q_learning_gridworld_step.sv */
// ============================================================================
// q_learning_gridworld_step
// Tabular Q-learning agent step: epsilon-greedy action, clamped move,
// fixed-point Q update, episode and epsilon bookkeeping.
// ============================================================================
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  item in  | start high while busy low   | i_item   (t_step_in)
//  result   | o_strobe, one cycle         | o_result (t_step_out)
//  config   | i_cfg_we, no wait           | i_cfg_index, i_cfg_data
//
//  A training step runs from the accept edge to the edge that takes the
//  result: current-row read, next-row read, next-state maximum, discount
//  multiply, then learning-rate multiply with write-back. busy falls with the
//  strobe, so the next item can go in while the strobe is high.
//  Once the episode limit is reached a step reports with training_done set.
//  Reset is synchronous; the Q table row valid bits clear at once, no sweep.
//  The result receiver cannot stall; each result shows for one cycle only.
//
module q_learning_gridworld_step #(
    parameter int GRID_DIM    = qlg_pkg::GRID_DIM_DEF,
    parameter int VALUE_WIDTH = qlg_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  qlg_pkg::t_step_in              i_item,
    output logic                           o_strobe,
    output qlg_pkg::t_step_out             o_result,
    input  logic                           i_cfg_we,
    input  logic [qlg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qlg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    qlg_pkg::t_qlg_cmd  cmd;
    qlg_pkg::t_qlg_stat stat;

    qlg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    qlg_dp #(
        .GRID_DIM    (GRID_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

endmodule
